/* design/ssr_pkg.sv */
// Shared constants, types and helper functions for the stream substring replace block.
package ssr_pkg;

    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 4;
    localparam int IDX_W           = 3;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 64;
    localparam int PAT_W           = MAX_PATTERN * BYTE_W;
    localparam int REPL_W          = MAX_REPLACEMENT * BYTE_W;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

    // One group of results caused by a single input transaction.
    typedef struct packed {
        logic [REPL_W-1:0] bytes;
        logic [LEN_W-1:0]  count;
        logic              last;
    } ssr_group_t;

    // Control broadcast to every window cell.
    typedef struct packed {
        logic accept;
        logic shift;
    } ssr_cell_ctrl_t;

    function automatic logic [LEN_W-1:0] sat_plen(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = LEN_W'(1);
        end
        else if (v > LEN_W'(MAX_PATTERN))
        begin
            r = LEN_W'(MAX_PATTERN);
        end
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] sat_rlen(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        r = v;
        if (v > LEN_W'(MAX_REPLACEMENT))
        begin
            r = LEN_W'(MAX_REPLACEMENT);
        end
        return r;
    endfunction

endpackage

/* design/ssr_cell.sv */
// One window cell: holds a pending byte, compares it with its pattern byte, shifts to its neighbor.
module ssr_cell import ssr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ssr_cell_ctrl_t       ctrl,
    input  logic                 sel_here,
    input  logic                 ignore,
    input  logic [BYTE_W-1:0]    in_byte,
    input  logic [BYTE_W-1:0]    pat_byte,
    input  logic [BYTE_W-1:0]    nbr_app,
    output logic [BYTE_W-1:0]    app_byte,
    output logic                 eq
);

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    // The incoming byte lands in the cell that sits at the current fill position.
    assign app_byte = sel_here ? in_byte : byte_reg;
    assign eq       = ignore || (app_byte == pat_byte);

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.accept)
        begin
            byte_next = ctrl.shift ? nbr_app : app_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

endmodule

/* design/ssr_out.sv */
// Output stage: a skid slot for result groups and a serializer that sends one byte per transaction.
module ssr_out import ssr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 grp_valid,
    input  ssr_group_t           grp,
    output logic                 grp_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [BYTE_W-1:0]    m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);

    logic             a_valid_reg, a_valid_next;
    ssr_group_t       a_grp_reg, a_grp_next;
    logic             b_valid_reg, b_valid_next;
    ssr_group_t       b_grp_reg, b_grp_next;
    logic [IDX_W-1:0] b_idx_reg, b_idx_next;
    logic             b_final;
    logic             b_free;

    assign b_final = (b_grp_reg.count == '0) ||
                     ((LEN_W'(b_idx_reg) + LEN_W'(1)) == b_grp_reg.count);
    assign b_free  = !b_valid_reg || (m_tready && b_final);

    assign grp_ready = !a_valid_reg;
    assign m_tvalid  = b_valid_reg;
    assign m_tuser   = (b_grp_reg.count != '0);
    assign m_tlast   = b_grp_reg.last && b_final;
    assign m_tdata   = m_tuser ? b_grp_reg.bytes[{b_idx_reg, 3'b000} +: BYTE_W] : '0;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        a_grp_next   = a_grp_reg;
        b_valid_next = b_valid_reg;
        b_grp_next   = b_grp_reg;
        b_idx_next   = b_idx_reg;
        if (b_free)
        begin
            b_idx_next = '0;
            if (a_valid_reg)
            begin
                b_valid_next = 1'b1;
                b_grp_next   = a_grp_reg;
                a_valid_next = 1'b0;
            end
            else if (grp_valid)
            begin
                b_valid_next = 1'b1;
                b_grp_next   = grp;
            end
            else
            begin
                b_valid_next = 1'b0;
            end
        end
        else
        begin
            if (m_tready)
            begin
                b_idx_next = b_idx_reg + IDX_W'(1);
            end
            if (grp_valid)
            begin
                a_valid_next = 1'b1;
                a_grp_next   = grp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            b_idx_reg   <= '0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            b_idx_reg   <= b_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_grp_reg <= a_grp_next;
        b_grp_reg <= b_grp_next;
    end

endmodule

/* design/stream_substring_replace.sv */
// Top level of the streaming replace-all block: window cell chain, match logic and output stage.
// A result group is registered in the serializer slot, or first in the skid slot while that is busy.
// Throughput: one input byte per cycle while each byte causes at most one result and m_tready
// stays high; a group of N results (replacement or final flush, N up to 8) is sent one byte per
// transfer; the single skid slot in the output stage lets one more group wait before input stalls.
// Reset (rst_n, asynchronous, active low) empties the window and output stage and restores
// pattern length 1, replacement length 0 and both byte registers to zero.
module stream_substring_replace import ssr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] in_byte
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [BYTE_W-1:0]     m_tdata,   // [7:0] out_byte
    output logic                  m_tuser,   // [0] byte_valid
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers. Lengths are saturated when written, so the datapath only
    // ever sees a pattern length of 1 to 8 and a replacement length of 0 to 8.
    logic [PAT_W-1:0]  pat_reg;
    logic [LEN_W-1:0]  plen_reg;
    logic [REPL_W-1:0] repl_reg;
    logic [LEN_W-1:0]  rlen_reg;

    // Number of pending bytes in the window; it always stays below the pattern length.
    logic [LEN_W-1:0]  fill_reg, fill_next;

    logic                       s_accept;
    logic [LEN_W-1:0]           fill_app;
    logic                       full;
    logic                       match;
    logic                       shift;
    ssr_cell_ctrl_t             cell_ctrl;
    logic [MAX_PATTERN-1:0]     eq;
    logic [BYTE_W-1:0]          app [MAX_PATTERN];
    logic [PAT_W-1:0]           app_bytes;
    logic                       grp_valid;
    logic                       grp_ready;
    ssr_group_t                 grp;

    assign s_tready = grp_ready;
    assign s_accept = s_tvalid && s_tready;

    // The window after appending the new byte is full when it reaches the pattern length.
    // A full window that matches in every used cell is replaced; a full window that does
    // not match lets its oldest byte go and every cell takes its neighbor's byte.
    assign fill_app = fill_reg + LEN_W'(1);
    assign full     = (fill_app == plen_reg);
    assign match    = full && (&eq);
    assign shift    = full && !match;

    assign cell_ctrl.accept = s_accept;
    assign cell_ctrl.shift  = shift;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PATTERN; gi++)
        begin : g_cell
            logic [BYTE_W-1:0] nbr;
            if (gi == MAX_PATTERN - 1)
            begin : g_end
                assign nbr = '0;
            end
            else
            begin : g_mid
                assign nbr = app[gi + 1];
            end

            ssr_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl),
                .sel_here (fill_reg == LEN_W'(gi)),
                .ignore   (LEN_W'(gi) >= plen_reg),
                .in_byte  (s_tdata),
                .pat_byte (pat_reg[gi * BYTE_W +: BYTE_W]),
                .nbr_app  (nbr),
                .app_byte (app[gi]),
                .eq       (eq[gi])
            );

            assign app_bytes[gi * BYTE_W +: BYTE_W] = app[gi];
        end
    endgenerate

    // Result group for this transaction. A match sends the replacement, and then nothing is
    // left to flush. Otherwise the group is taken from the front of the appended window:
    // one byte when the window slides, or every pending byte when the text ends. An empty
    // group that carries the end mark becomes the empty end marker in the output stage.
    always_comb
    begin
        grp.last = s_tlast;
        if (match)
        begin
            grp.bytes = repl_reg;
            grp.count = rlen_reg;
        end
        else
        begin
            grp.bytes = app_bytes;
            grp.count = s_tlast ? fill_app : LEN_W'(1);
        end
    end

    assign grp_valid = s_accept && (s_tlast || shift || (match && (rlen_reg != '0)));

    always_comb
    begin
        fill_next = fill_reg;
        if (cfg_we && (cfg_index == REG_PATTERN_LENGTH))
        begin
            fill_next = '0;
        end
        else if (s_accept)
        begin
            if (s_tlast || match)
            begin
                fill_next = '0;
            end
            else if (shift)
            begin
                fill_next = plen_reg - LEN_W'(1);
            end
            else
            begin
                fill_next = fill_app;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            pat_reg  <= '0;
            plen_reg <= LEN_W'(1);
            repl_reg <= '0;
            rlen_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PATTERN_BYTES:      pat_reg  <= cfg_data[PAT_W-1:0];
                    REG_PATTERN_LENGTH:     plen_reg <= sat_plen(cfg_data[LEN_W-1:0]);
                    REG_REPLACEMENT_BYTES:  repl_reg <= cfg_data[REPL_W-1:0];
                    REG_REPLACEMENT_LENGTH: rlen_reg <= sat_rlen(cfg_data[LEN_W-1:0]);
                    default:                ;
                endcase
            end
        end
    end

    ssr_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_valid (grp_valid),
        .grp       (grp),
        .grp_ready (grp_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
